/* rtl/core/kfrq_pkg.sv */
// Package with the beat types, operation and status codes shared by the queue modules.
`timescale 1ns / 1ps

package kfrq_pkg;

	localparam int ID_W   = 16;
	localparam int CPY_W  = 8;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 3;
	localparam int POS_W  = 5;

	typedef enum logic [FUNC_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_POP    = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_AVAIL    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SCAN,
		CS_COMMIT
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   requester_id;
		logic [CPY_W-1:0]  copies_available;
	} req_beat_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   popped_id;
		logic [POS_W-1:0]  position;
		logic              is_member;
		logic [POS_W-1:0]  occupancy;
	} rsp_beat_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/kfrq_ctrl.sv */
// Controller state machine that sequences load, scan and commit of one operation.
`timescale 1ns / 1ps

module kfrq_ctrl import kfrq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CS_IDLE: begin
				if (req_valid) state_nxt = CS_SCAN;
			end
			CS_SCAN: begin
				if (sts.scan_done) state_nxt = CS_COMMIT;
			end
			CS_COMMIT: begin
				if (sts.out_free) state_nxt = CS_IDLE;
			end
			default: state_nxt = CS_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = 1'b1;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			CS_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			CS_SCAN: begin
				cmd.scan = 1'b1;
			end
			CS_COMMIT: begin
				cmd.commit = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/core/kfrq_dp.sv */
// Datapath with the entry memory, the scan and compaction pipeline and the result register.
`timescale 1ns / 1ps

module kfrq_dp import kfrq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_beat_t req,
	input  cmd_t      cmd,
	output sts_t      sts,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic [ID_W-1:0] mem [QUEUE_DEPTH];

	op_t             op_q;
	logic [ID_W-1:0] id_q;
	logic            copies_zero_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_idx_q;
	logic            found_q;
	logic [ID_W-1:0] head_q;
	logic [AW-1:0]   idx_s1;
	logic            vld_s1;
	logic [ID_W-1:0] rd_s1;
	rsp_beat_t       rsp_q;
	logic            rsp_valid_q;

	logic            shift_op;
	logic            hit;
	logic            issue;
	logic            shift_wr;
	logic            add_wr;
	logic [CW-1:0]   new_count;
	rsp_beat_t       res;

	// Remove and pop keep walking after the match to close the gap; add and
	// query stop at the first match.
	assign shift_op = (op_q == OP_REMOVE) || (op_q == OP_POP);
	assign hit      = vld_s1 && !found_q &&
		((op_q == OP_POP) ? (idx_s1 == '0) : (rd_s1 == id_q));
	assign issue    = cmd.scan && (rd_idx_q < count_q) &&
		!(!shift_op && (found_q || hit));
	assign shift_wr = cmd.scan && vld_s1 && found_q && shift_op;

	assign sts.scan_done = !vld_s1 &&
		((rd_idx_q >= count_q) || (!shift_op && found_q));
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		res        = '0;
		res.status = ST_OK;
		new_count  = count_q;
		add_wr     = 1'b0;
		case (op_q)
			OP_ADD: begin
				res.is_member = found_q;
				if (found_q) begin
					res.status = ST_DUP;
				end else if (!copies_zero_q) begin
					res.status = ST_AVAIL;
				end else if (count_q == DEPTH_C) begin
					res.status = ST_FULL;
				end else begin
					add_wr       = cmd.commit;
					new_count    = count_q + CW'(1);
					res.position = POS_W'(new_count);
				end
			end
			OP_REMOVE: begin
				if (count_q == '0) begin
					res.status = ST_EMPTY;
				end else if (found_q) begin
					res.is_member = 1'b1;
					new_count     = count_q - CW'(1);
				end else begin
					res.status = ST_NOTFOUND;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					res.status = ST_EMPTY;
				end else begin
					res.popped_id = head_q;
					new_count     = count_q - CW'(1);
				end
			end
			OP_QUERY: begin
				res.is_member = found_q;
			end
			default: ;
		endcase
		res.occupancy = POS_W'(new_count);
	end

	// One read and one write port; the compaction write address always trails the read.
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= mem[rd_idx_q[AW-1:0]];
		end
		if (shift_wr) begin
			mem[idx_s1 - AW'(1)] <= rd_s1;
		end else if (add_wr) begin
			mem[count_q[AW-1:0]] <= id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q          <= op_t'(req.func);
			id_q          <= req.requester_id;
			copies_zero_q <= (req.copies_available == '0);
		end
		idx_s1 <= rd_idx_q[AW-1:0];
		if (hit && (op_q == OP_POP)) begin
			head_q <= rd_s1;
		end
		if (cmd.commit) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_idx_q    <= '0;
			found_q     <= 1'b0;
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (cmd.load) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
			end else begin
				if (issue) rd_idx_q <= rd_idx_q + CW'(1);
				if (cmd.scan && hit) found_q <= 1'b1;
			end
			if (cmd.commit) begin
				count_q     <= new_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count exceeds depth");

	a_count_only_at_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(count_q))
		else $error("queue count changed outside commit");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid_q || !rsp_stall))
		else $error("commit while a result beat is still held");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(cmd.commit))
		else $error("result beat raised without a commit");

	a_shift_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		shift_wr |-> (idx_s1 != '0) && !add_wr)
		else $error("compaction write without a match before it");

endmodule

/* rtl/core/keyed_fifo_reservation_queue.sv */
// Top level of the keyed FIFO reservation queue: controller plus datapath.
`timescale 1ns / 1ps

// A bounded FIFO of requester IDs waiting for one resource. Each request beat
// on the req channel carries an operation (add, remove by ID, pop head or
// membership query), an ID and the count of free copies; each one produces
// exactly one response beat on the rsp channel with a status, the popped ID,
// the new position of an added ID, a membership flag and the occupancy.
// Both channels use valid and stall; a beat moves on a clock edge where valid
// is high and stall is low.
// The block handles one operation at a time. A request beat is taken, then the
// entry memory is walked one entry per cycle over its single read port,
// compacting entries behind a removed or popped one as it goes, then a commit
// writes the response register; add or query stop early at the first match.
// The response register separates the channels: once a result is committed,
// the next request is taken even while the receiver stalls that response;
// a commit waits only if the previous response is still held.
// Asynchronous reset empties the queue and drops any pending response; the
// memory contents are not cleared, as no entry at or beyond the count is read.

module keyed_fifo_reservation_queue import kfrq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	cmd_t cmd;
	sts_t sts;

	kfrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	kfrq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
